// ===== sv/dnr_pkg.sv =====
// Shared types and constants for the decimal normalise-and-round block.
`default_nettype none
package dnr_pkg;

   localparam int unsigned DNR_EXT_WORDS = 7;
   localparam int unsigned DNR_MAX_SCALE = 28;

   localparam int unsigned WORD_BITS  = 32;
   localparam int unsigned IN_BITS    = 224;
   localparam int unsigned RES_BITS   = 96;
   localparam int unsigned SCALE_BITS = 6;
   localparam int unsigned DIGIT_BITS = 4;

   localparam logic [DIGIT_BITS-1:0] HALF_DIGIT = 4'd5;

   // Word step of the divide-by-ten unit: {rem, w} / 10 is split as
   // rem * floor(2^32 / 10) + (rem * 6 + w) / 10, the latter by reciprocal.
   localparam int unsigned PART_BITS   = 34;
   localparam int unsigned PROD_BITS   = 67;
   localparam int unsigned RECIP_SHIFT = 36;
   localparam int unsigned QLO_BITS    = 31;
   localparam logic [32:0] RECIP_TEN   = 33'd6871947674;
   localparam logic [WORD_BITS-1:0] TWO32_DIV10 = 32'd429496729;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_OVERFLOW = 2'd1,
      STATUS_ZERO_MAX = 2'd2
   } dnr_status_type;

   typedef struct packed {
      logic [63:0]           mant_w0;
      logic [63:0]           mant_w1;
      logic [63:0]           mant_w2;
      logic [31:0]           mant_w3;
      logic [SCALE_BITS-1:0] scale_in;
   } dnr_req_type;

   typedef struct packed {
      logic [63:0]           res_low;
      logic [31:0]           res_high;
      logic [SCALE_BITS-1:0] scale_out;
      dnr_status_type        status;
   } dnr_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_ROUND,
      ST_EMIT
   } dnr_state_type;

   typedef struct packed {
      logic load;
      logic pass_start;
      logic div_step;
      logic pass_end;
      logic round;
      logic emit;
   } dnr_cmd_type;

   typedef struct packed {
      logic high_nz;
      logic scale_nz;
      logic scale_gt_max;
   } dnr_sts_type;

endpackage
`default_nettype wire

// ===== sv/dnr_datapath.sv =====
// Datapath: wide mantissa register, word-serial divide-by-ten, rounding, result register.
`default_nettype none
module dnr_datapath #(
   parameter int unsigned EXT_WORDS = dnr_pkg::DNR_EXT_WORDS,
   parameter int unsigned MAX_SCALE = dnr_pkg::DNR_MAX_SCALE
) (
   input  logic                clock,
   input  dnr_pkg::dnr_cmd_type cmd,
   input  dnr_pkg::dnr_req_type req_data,
   output dnr_pkg::dnr_sts_type sts,
   output dnr_pkg::dnr_rsp_type rsp_data
);
   import dnr_pkg::*;

   localparam int unsigned MANT_BITS = EXT_WORDS * WORD_BITS;

   logic [MANT_BITS-1:0]  mant_ff, mant_in, mant_load;
   logic [IN_BITS-1:0]    in_mant;
   logic [SCALE_BITS-1:0] scale_ff, scale_in;
   logic [DIGIT_BITS-1:0] rem_ff, rem_in, last_ff, last_in, rem_digit;
   logic                  sticky_ff, sticky_in, divided_ff, divided_in;
   dnr_rsp_type           rsp_ff, rsp_in;

   logic [WORD_BITS-1:0]  top_word, quot_word;
   logic [PART_BITS-1:0]  part, back, diff;
   logic [PROD_BITS-1:0]  prod;
   logic [QLO_BITS-1:0]   quot_lo;
   logic                  high_nz, round_up;
   dnr_status_type        status_code;

   assign in_mant = {req_data.mant_w3, req_data.mant_w2, req_data.mant_w1, req_data.mant_w0};

   generate
      if (MANT_BITS <= IN_BITS) begin : g_trunc
         assign mant_load = in_mant[MANT_BITS-1:0];
      end else begin : g_extend
         assign mant_load = {{(MANT_BITS-IN_BITS){1'b0}}, in_mant};
      end
   endgenerate

   // One word of the long division: top word rotates out, quotient word rotates in.
   assign top_word  = mant_ff[MANT_BITS-1 -: WORD_BITS];
   assign part      = PART_BITS'({rem_ff, 2'b00}) + PART_BITS'({rem_ff, 1'b0})
                      + PART_BITS'(top_word);
   assign prod      = PROD_BITS'(part) * PROD_BITS'(RECIP_TEN);
   assign quot_lo   = prod[RECIP_SHIFT +: QLO_BITS];
   assign back      = PART_BITS'({quot_lo, 3'b000}) + PART_BITS'({quot_lo, 1'b0});
   assign diff      = part - back;
   assign rem_digit = diff[DIGIT_BITS-1:0];
   assign quot_word = WORD_BITS'(rem_ff) * TWO32_DIV10 + WORD_BITS'(quot_lo);

   assign high_nz  = |mant_ff[MANT_BITS-1:RES_BITS];
   assign round_up = divided_ff && ((last_ff > HALF_DIGIT) ||
                     ((last_ff == HALF_DIGIT) && (sticky_ff || mant_ff[0])));

   always_comb begin
      if (high_nz) begin
         status_code = STATUS_OVERFLOW;
      end else if ((scale_ff == SCALE_BITS'(MAX_SCALE)) && (mant_ff[RES_BITS-1:0] == '0)) begin
         status_code = STATUS_ZERO_MAX;
      end else begin
         status_code = STATUS_OK;
      end
   end

   always_comb begin
      mant_in    = mant_ff;
      scale_in   = scale_ff;
      rem_in     = rem_ff;
      last_in    = last_ff;
      sticky_in  = sticky_ff;
      divided_in = divided_ff;
      rsp_in     = rsp_ff;
      if (cmd.load) begin
         mant_in    = mant_load;
         scale_in   = req_data.scale_in;
         last_in    = '0;
         sticky_in  = 1'b0;
         divided_in = 1'b0;
      end
      if (cmd.pass_start) begin
         // fold the previous discarded digit into the sticky flag
         sticky_in = sticky_ff | (divided_ff && (last_ff != '0));
         rem_in    = '0;
      end
      if (cmd.div_step) begin
         mant_in = {mant_ff[MANT_BITS-WORD_BITS-1:0], quot_word};
         rem_in  = rem_digit;
      end
      if (cmd.pass_end) begin
         last_in    = rem_digit;
         divided_in = 1'b1;
         scale_in   = scale_ff - SCALE_BITS'(1);
      end
      if (cmd.round) begin
         mant_in = mant_ff + MANT_BITS'(round_up);
      end
      if (cmd.emit) begin
         rsp_in.res_low   = mant_ff[63:0];
         rsp_in.res_high  = mant_ff[RES_BITS-1:64];
         rsp_in.scale_out = scale_ff;
         rsp_in.status    = status_code;
      end
   end

   always_ff @(posedge clock) begin
      mant_ff    <= mant_in;
      scale_ff   <= scale_in;
      rem_ff     <= rem_in;
      last_ff    <= last_in;
      sticky_ff  <= sticky_in;
      divided_ff <= divided_in;
      rsp_ff     <= rsp_in;
   end

   assign sts.high_nz      = high_nz;
   assign sts.scale_nz     = (scale_ff != '0);
   assign sts.scale_gt_max = (scale_ff > SCALE_BITS'(MAX_SCALE));
   assign rsp_data         = rsp_ff;

endmodule
`default_nettype wire

// ===== sv/dnr_ctrl.sv =====
// Controller: sequences division passes, rounding and the result handshake.
`default_nettype none
module dnr_ctrl #(
   parameter int unsigned EXT_WORDS = dnr_pkg::DNR_EXT_WORDS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  dnr_pkg::dnr_sts_type sts,
   output dnr_pkg::dnr_cmd_type cmd
);
   import dnr_pkg::*;

   localparam int unsigned CNT_BITS = (EXT_WORDS > 2) ? $clog2(EXT_WORDS) : 1;

   dnr_state_type       state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                need_div, cnt_last, out_free;

   assign need_div = (sts.high_nz && sts.scale_nz) || sts.scale_gt_max;
   assign cnt_last = (cnt_ff == CNT_BITS'(EXT_WORDS - 1));
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_CHECK;
         ST_CHECK: state_in = need_div ? ST_DIV : ST_ROUND;
         ST_DIV:   if (cnt_last) state_in = ST_CHECK;
         ST_ROUND: state_in = ST_EMIT;
         ST_EMIT:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      cnt_in    = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_CHECK: begin
            cmd.pass_start = need_div;
            cnt_in         = '0;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cmd.pass_end = cnt_last;
            cnt_in       = cnt_ff + CNT_BITS'(1);
         end
         ST_ROUND: cmd.round = 1'b1;
         ST_EMIT:  cmd.emit  = out_free;
         default:  cmd       = '0;
      endcase
   end

   // hold the result until taken; a new one only lands in a free register
   assign rsp_valid_in = cmd.emit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ===== sv/decimal_normalize_round.sv =====
// Top level of the decimal normalise-and-round block.
// Normalises a wide unsigned decimal mantissa to 96 bits with round-half-even.
// Each divide by ten runs through one 32-bit word per cycle in a shared
// reciprocal-multiply unit, after a decision step that checks whether the
// division is needed. An item needs at most scale_in divisions before it is
// rounded and its result registered. A new item is accepted while the previous
// result still waits in the output register.
`default_nettype none
module decimal_normalize_round #(
   parameter int unsigned EXT_WORDS = dnr_pkg::DNR_EXT_WORDS,
   parameter int unsigned MAX_SCALE = dnr_pkg::DNR_MAX_SCALE
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  dnr_pkg::dnr_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output dnr_pkg::dnr_rsp_type rsp_data
);
   import dnr_pkg::*;

   dnr_cmd_type cmd;
   dnr_sts_type sts;

   dnr_ctrl #(
      .EXT_WORDS (EXT_WORDS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   dnr_datapath #(
      .EXT_WORDS (EXT_WORDS),
      .MAX_SCALE (MAX_SCALE)
   ) u_datapath (
      .clock    (clock),
      .cmd      (cmd),
      .req_data (req_data),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire

// ===== sv/dnr_checker.sv =====
// Port-level checks for the decimal normalise-and-round block, bound to the top level.
`default_nettype none
module dnr_checker #(
   parameter int unsigned MAX_SCALE = dnr_pkg::DNR_MAX_SCALE
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input dnr_pkg::dnr_rsp_type rsp_data
);
   import dnr_pkg::*;

   // an accepted item keeps the block busy for at least the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input ready straight after an accepted item");

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result dropped or changed");

   a_zero_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_ZERO_MAX) |->
         (rsp_data.res_low == '0) && (rsp_data.res_high == '0) &&
         (rsp_data.scale_out == 6'(MAX_SCALE)))
      else $error("zero status with nonzero mantissa or wrong scale");

   a_scale_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != STATUS_OVERFLOW) |->
         (rsp_data.scale_out <= 6'(MAX_SCALE)))
      else $error("scale above maximum without overflow");

endmodule

bind decimal_normalize_round dnr_checker #(
   .MAX_SCALE (MAX_SCALE)
) u_dnr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire

// ===== sim/tb_decimal_normalize_round.sv =====
// Self-checking testbench for the decimal normalise-and-round block.
module tb_decimal_normalize_round;
   timeunit 1ns;
   timeprecision 1ps;

   import dnr_pkg::*;

   localparam int unsigned IDLE_MAX     = 13;
   localparam int unsigned RANDOM_ITEMS = 1950;
   localparam int unsigned DRAIN_CYCLES = 600;
   localparam longint unsigned CYCLE_LIMIT = 64'd4_000_000;

   localparam logic [IN_BITS-1:0] MANT_ONE = 1;
   localparam logic [IN_BITS-1:0] MANT_TEN = 10;
   localparam logic [IN_BITS-1:0] RES_MAX  = (MANT_ONE << RES_BITS) - MANT_ONE;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   dnr_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   dnr_rsp_type rsp_data;

   dnr_rsp_type     rounded_q[$];
   int unsigned     mismatch_count = 0;
   int unsigned     rsp_hold = 0;
   bit              idle_on = 1'b1;
   longint unsigned cycle_count = 0;

   decimal_normalize_round i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic int unsigned draw_gap();
      return idle_on ? $urandom_range(0, IDLE_MAX) : 0;
   endfunction

   // Divide by ten until the top bits are clear (scale permitting) and the
   // scale is in range, then round half to even on the last discarded digit.
   function automatic dnr_rsp_type normalise_round(input dnr_req_type item);
      logic [IN_BITS-1:0]    mant;
      logic [IN_BITS-1:0]    rem;
      logic [DIGIT_BITS-1:0] digit;
      int unsigned           scale;
      bit                    sticky;
      bit                    divided;
      bit                    up;
      dnr_rsp_type           res;
      mant    = {item.mant_w3, item.mant_w2, item.mant_w1, item.mant_w0};
      scale   = item.scale_in;
      digit   = '0;
      sticky  = 1'b0;
      divided = 1'b0;
      while ((mant[IN_BITS-1:RES_BITS] != '0 && scale > 0) || scale > DNR_MAX_SCALE) begin
         if (divided && digit != '0) sticky = 1'b1;
         rem     = mant % MANT_TEN;
         digit   = rem[DIGIT_BITS-1:0];
         mant    = mant / MANT_TEN;
         divided = 1'b1;
         scale--;
      end
      if (divided) begin
         up = (digit > HALF_DIGIT) || (digit == HALF_DIGIT && (sticky || mant[0]));
         if (up) mant = mant + MANT_ONE;
      end
      res.res_low   = mant[63:0];
      res.res_high  = mant[95:64];
      res.scale_out = scale[SCALE_BITS-1:0];
      if (mant[IN_BITS-1:RES_BITS] != '0)
         res.status = STATUS_OVERFLOW;
      else if (scale == DNR_MAX_SCALE && mant[RES_BITS-1:0] == '0)
         res.status = STATUS_ZERO_MAX;
      else
         res.status = STATUS_OK;
      return res;
   endfunction

   function automatic logic [IN_BITS-1:0] rand_mantissa(input int unsigned len);
      logic [IN_BITS-1:0] mant;
      mant = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      if (len < IN_BITS) mant &= (MANT_ONE << len) - MANT_ONE;
      return mant;
   endfunction

   task automatic send_mantissa(input logic [IN_BITS-1:0] mant, input int unsigned scale);
      dnr_req_type item;
      int unsigned gap;
      item.mant_w0  = mant[63:0];
      item.mant_w1  = mant[127:64];
      item.mant_w2  = mant[191:128];
      item.mant_w3  = mant[223:192];
      item.scale_in = scale[SCALE_BITS-1:0];
      gap = draw_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      rounded_q.push_back(normalise_round(item));
   endtask

   always @(posedge clock) begin
      dnr_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (rounded_q.size() == 0) begin
            $error("unexpected item: res_low %h res_high %h scale_out %0d status %0d",
                   rsp_data.res_low, rsp_data.res_high, rsp_data.scale_out, rsp_data.status);
            mismatch_count++;
         end else begin
            want = rounded_q.pop_front();
            if (rsp_data.res_low !== want.res_low) begin
               $error("res_low: expected %h, got %h", want.res_low, rsp_data.res_low);
               mismatch_count++;
            end
            if (rsp_data.res_high !== want.res_high) begin
               $error("res_high: expected %h, got %h", want.res_high, rsp_data.res_high);
               mismatch_count++;
            end
            if (rsp_data.scale_out !== want.scale_out) begin
               $error("scale_out: expected %0d, got %0d", want.scale_out, rsp_data.scale_out);
               mismatch_count++;
            end
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               mismatch_count++;
            end
         end
         rsp_hold = draw_gap();
      end
   end

   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic test_limits();
      send_mantissa('0, 0);
      send_mantissa('0, DNR_MAX_SCALE);
      send_mantissa('0, 63);
      send_mantissa('1, 0);
      send_mantissa('1, 5);
      send_mantissa('1, 63);
      send_mantissa(RES_MAX, DNR_MAX_SCALE);
      send_mantissa(RES_MAX, 63);
      send_mantissa(MANT_ONE << RES_BITS, 0);
      send_mantissa(MANT_ONE << RES_BITS, 1);
      send_mantissa(MANT_ONE, DNR_MAX_SCALE + 1);
      send_mantissa(MANT_ONE, DNR_MAX_SCALE - 1);
   endtask

   task automatic test_rounding();
      logic [IN_BITS-1:0] q_even;
      q_even = MANT_ONE << 93;
      // ties with no sticky digit go to even, either way
      send_mantissa(q_even * MANT_TEN + 5, 1);
      send_mantissa((q_even + MANT_ONE) * MANT_TEN + 5, 1);
      send_mantissa(q_even * 100 + 50, 2);
      // a nonzero digit below the tie breaks it upwards; other digits round to nearest
      send_mantissa(q_even * 100 + 51, 2);
      send_mantissa(q_even * MANT_TEN + 7, 1);
      send_mantissa(q_even * MANT_TEN + 4, 1);
      // rounding carry out of 96 bits
      send_mantissa(RES_MAX * MANT_TEN + 9, 1);
      send_mantissa(RES_MAX * MANT_TEN + 5, 1);
      send_mantissa(RES_MAX * MANT_TEN + 5, DNR_MAX_SCALE + 1);
      // reduction down to the scale ceiling, rounding to zero or not
      send_mantissa(5, DNR_MAX_SCALE + 1);
      send_mantissa(15, DNR_MAX_SCALE + 1);
      send_mantissa(35, DNR_MAX_SCALE + 1);
   endtask

   task automatic test_random_mix();
      logic [IN_BITS-1:0] mant;
      logic [IN_BITS-1:0] quot;
      logic [IN_BITS-1:0] pow;
      logic [IN_BITS-1:0] tail;
      int unsigned        k;
      int unsigned        top_digit;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 64 == 0) idle_on = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 9))
            0, 1: begin
               send_mantissa(rand_mantissa(IN_BITS), $urandom_range(0, 63));
            end
            2, 3, 4: begin
               mant = rand_mantissa($urandom_range(0, IN_BITS));
               send_mantissa(mant, ($urandom_range(0, 7) == 0) ? $urandom_range(41, 63)
                                                              : $urandom_range(0, 40));
            end
            5, 6: begin
               // build the discarded digits so that ties and near-ties are common
               k = $urandom_range(1, 4);
               pow = MANT_ONE;
               repeat (k) pow = pow * MANT_TEN;
               top_digit = $urandom_range(4, 7);
               if (top_digit == 7) top_digit = 5;
               tail = (pow / MANT_TEN) * top_digit;
               if ($urandom_range(0, 1)) tail += rand_mantissa(32) % (pow / MANT_TEN);
               if ($urandom_range(0, 1)) begin
                  quot = rand_mantissa($urandom_range(94, RES_BITS)) | (MANT_ONE << 93);
                  send_mantissa(quot * pow + tail, k + $urandom_range(0, 2));
               end else begin
                  quot = rand_mantissa($urandom_range(0, 64));
                  send_mantissa(quot * pow + tail, DNR_MAX_SCALE + k);
               end
            end
            7: begin
               mant = (RES_MAX - rand_mantissa(4)) * MANT_TEN + $urandom_range(0, 9);
               send_mantissa(mant, ($urandom_range(0, 3) == 0) ? DNR_MAX_SCALE + 1
                                                              : $urandom_range(0, 2));
            end
            8: begin
               mant = (MANT_ONE << $urandom_range(0, IN_BITS - 1))
                      | rand_mantissa($urandom_range(0, 16));
               send_mantissa(mant, $urandom_range(0, 63));
            end
            default: begin
               send_mantissa(rand_mantissa($urandom_range(0, 40)),
                             $urandom_range(DNR_MAX_SCALE + 1, 63));
            end
         endcase
      end
      idle_on = 1'b1;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_limits();
      test_rounding();
      test_random_mix();

      @(negedge clock);
      req_valid <= 1'b0;
      while (rounded_q.size() != 0) @(posedge clock);
      // let any stray item surface
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
